// ===== rtl/core/pssa_pkg.sv =====
package pssa_pkg;

    // Item codes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [15:0] TIME_MAX = 16'hFFFF;

    // One input beat
    typedef struct packed {
        logic        mode;
        logic [2:0]  slot;
        logic [15:0] arrival_time;
        logic [11:0] burst_time;
        logic [7:0]  start_priority;
    } in_item_t;

    // One result beat
    typedef struct packed {
        logic [15:0] now_time;
        logic        idle_tick;
        logic [2:0]  run_slot;
        logic        preempted;
        logic [2:0]  preempted_slot;
        logic        first_run;
        logic [15:0] response_time;
        logic        completed;
        logic [15:0] turnaround_time;
        logic [15:0] waiting_time;
    } out_item_t;

    // Per-slot task record held in the task RAM
    typedef struct packed {
        logic [15:0] arrival;
        logic [11:0] burst;
        logic [11:0] remaining;
        logic [7:0]  prio;
        logic        started;
        logic        done;
    } task_rec_t;

endpackage

// ===== rtl/core/pssa_ram.sv =====
module pssa_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/preemptive_priority_scheduler_aging_unit.sv =====
// Tick-driven preemptive priority scheduler with aging. A load beat (mode 0)
// writes one task slot and gives no result; busy stays low. A tick beat
// (mode 1) holds busy through the scan and serve states and then strobes
// result_valid for one cycle; a new tick is taken only once busy is low. The
// scan is one pass over the task RAM, one slot record read per cycle through
// its single read port, selecting the next task and ageing each eligible
// record as it goes; the serve state then serves the selected task. The
// result is presented for exactly one cycle and cannot be held off by the
// receiver.
module preemptive_priority_scheduler_aging_unit #(
    parameter int SLOTS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pssa_pkg::in_item_t item,
    output logic               result_valid,
    output pssa_pkg::out_item_t result
);
    import pssa_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int REC_W = $bits(task_rec_t);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SERVE
    } state_t;

    state_t             state_reg, state_next;
    logic [15:0]        time_reg, time_next;
    logic               run_valid_reg, run_valid_next;
    logic [IDX_W-1:0]   run_slot_reg, run_slot_next;
    logic [SLOTS-1:0]   slot_valid_reg, slot_valid_next;
    logic [CNT_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   sel_reg, sel_next;
    task_rec_t          best_reg, best_next;
    logic [7:0]         run_prio_reg, run_prio_next;
    logic               result_valid_reg, result_valid_next;
    out_item_t          result_reg, result_next;

    // RAM ports
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    task_rec_t          wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [REC_W-1:0]   rd_raw;
    task_rec_t          rd_rec;

    // Datapath helpers
    logic [15:0]        t0;
    logic [15:0]        t1;
    logic               elig0;
    logic               elig1;
    logic               load_ok;
    logic [IDX_W-1:0]   load_idx;
    logic [11:0]        rem_dec;
    logic               finishes;
    logic [15:0]        ta;
    logic [15:0]        burst_ext;
    logic               load_we;
    logic               age_we;

    assign rd_rec = task_rec_t'(rd_raw);
    assign busy   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    // Time at tick start and after it, saturating
    assign t0 = time_reg;
    assign t1 = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + 16'd1;

    // Eligibility of the record on the read port, before and after the tick
    assign elig0 = slot_valid_reg[rd_idx_reg] && !rd_rec.done && (rd_rec.arrival <= t0);
    assign elig1 = slot_valid_reg[rd_idx_reg] && !rd_rec.done && (rd_rec.arrival <= t1);

    assign load_ok  = (7'(item.slot) < 7'(SLOTS));
    assign load_idx = IDX_W'(item.slot);

    // Service of the selected task
    assign rem_dec   = (best_reg.remaining != 12'd0) ? best_reg.remaining - 12'd1
                                                     : best_reg.remaining;
    assign finishes  = (rem_dec == 12'd0);
    assign ta        = t1 - best_reg.arrival;
    assign burst_ext = 16'(best_reg.burst);

    pssa_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS)
    ) u_task_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (REC_W'(wr_data)),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_raw)
    );

    // Next-state and RAM access logic
    always_comb
    begin
        state_next        = state_reg;
        time_next         = time_reg;
        run_valid_next    = run_valid_reg;
        run_slot_next     = run_slot_reg;
        slot_valid_next   = slot_valid_reg;
        issue_cnt_next    = issue_cnt_reg;
        rd_vld_next       = 1'b0;
        rd_idx_next       = rd_idx_reg;
        found_next        = found_reg;
        sel_next          = sel_reg;
        best_next         = best_reg;
        run_prio_next     = run_prio_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        wr_en             = 1'b0;
        wr_addr           = rd_idx_reg;
        wr_data           = rd_rec;
        rd_en             = 1'b0;
        rd_addr           = issue_cnt_reg[IDX_W-1:0];
        load_we           = 1'b0;
        age_we            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (item.mode == MODE_LOAD)
                    begin
                        // Write the slot record in place
                        if (load_ok)
                        begin
                            load_we                   = 1'b1;
                            wr_en                     = 1'b1;
                            wr_addr                   = load_idx;
                            wr_data.arrival           = item.arrival_time;
                            wr_data.burst             = item.burst_time;
                            wr_data.remaining         = item.burst_time;
                            wr_data.prio              = item.start_priority;
                            wr_data.started           = 1'b0;
                            wr_data.done              = (item.burst_time == 12'd0);
                            slot_valid_next[load_idx] = 1'b1;
                            if (run_valid_reg && run_slot_reg == load_idx)
                            begin
                                run_valid_next = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        state_next     = S_SCAN;
                        issue_cnt_next = '0;
                        found_next     = 1'b0;
                        sel_next       = '0;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue one slot read per cycle
                if (issue_cnt_reg != CNT_W'(SLOTS))
                begin
                    rd_en          = 1'b1;
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    rd_vld_next    = 1'b1;
                    rd_idx_next    = issue_cnt_reg[IDX_W-1:0];
                end
                // Select, capture the running task's priority, age
                if (rd_vld_reg)
                begin
                    if (elig0 && (!found_reg || rd_rec.prio < best_reg.prio))
                    begin
                        found_next = 1'b1;
                        sel_next   = rd_idx_reg;
                        best_next  = rd_rec;
                    end
                    if (rd_idx_reg == run_slot_reg)
                    begin
                        run_prio_next = rd_rec.prio;
                    end
                    if (elig1 && rd_rec.prio != 8'd0)
                    begin
                        age_we       = 1'b1;
                        wr_en        = 1'b1;
                        wr_addr      = rd_idx_reg;
                        wr_data      = rd_rec;
                        wr_data.prio = rd_rec.prio - 8'd1;
                    end
                    if (issue_cnt_reg == CNT_W'(SLOTS))
                    begin
                        state_next = S_SERVE;
                    end
                end
            end

            S_SERVE:
            begin
                state_next        = S_IDLE;
                time_next         = t1;
                result_valid_next = 1'b1;
                result_next       = '0;
                result_next.now_time = t1;
                if (found_reg)
                begin
                    result_next.run_slot = 3'(sel_reg);
                    if (!best_reg.started)
                    begin
                        result_next.first_run     = 1'b1;
                        result_next.response_time = t0 - best_reg.arrival;
                    end
                    if (run_valid_reg && run_slot_reg != sel_reg &&
                        best_reg.prio < run_prio_reg)
                    begin
                        result_next.preempted      = 1'b1;
                        result_next.preempted_slot = 3'(run_slot_reg);
                    end
                    if (finishes)
                    begin
                        result_next.completed       = 1'b1;
                        result_next.turnaround_time = ta;
                        result_next.waiting_time    = (ta >= burst_ext) ? ta - burst_ext
                                                                        : 16'd0;
                    end
                    run_valid_next = !finishes;
                    run_slot_next  = sel_reg;

                    // Write back the served record; an unfinished task also ages
                    wr_en             = 1'b1;
                    wr_addr           = sel_reg;
                    wr_data           = best_reg;
                    wr_data.remaining = rem_dec;
                    wr_data.started   = 1'b1;
                    wr_data.done      = finishes;
                    if (!finishes && best_reg.prio != 8'd0)
                    begin
                        wr_data.prio = best_reg.prio - 8'd1;
                    end
                end
                else
                begin
                    result_next.idle_tick = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            time_reg         <= '0;
            run_valid_reg    <= 1'b0;
            run_slot_reg     <= '0;
            slot_valid_reg   <= '0;
            issue_cnt_reg    <= '0;
            rd_vld_reg       <= 1'b0;
            rd_idx_reg       <= '0;
            found_reg        <= 1'b0;
            sel_reg          <= '0;
            best_reg         <= '0;
            run_prio_reg     <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            time_reg         <= time_next;
            run_valid_reg    <= run_valid_next;
            run_slot_reg     <= run_slot_next;
            slot_valid_reg   <= slot_valid_next;
            issue_cnt_reg    <= issue_cnt_next;
            rd_vld_reg       <= rd_vld_next;
            rd_idx_reg       <= rd_idx_next;
            found_reg        <= found_next;
            sel_reg          <= sel_next;
            best_reg         <= best_next;
            run_prio_reg     <= run_prio_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    // A result beat only follows the serve cycle
    a_result_after_serve: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_SERVE))
        else $error("result beat without a serve cycle");

    // The block is free again when a result is shown
    a_result_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while busy");

    // Load writes and ageing writes never collide on the RAM port
    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(load_we && age_we))
        else $error("load and ageing write in the same cycle");

    // An idle tick reports no service
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.idle_tick) |->
            (!result.completed && !result.first_run && !result.preempted))
        else $error("idle tick carries service flags");

    // The running task always sits in a loaded slot
    a_running_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> slot_valid_reg[run_slot_reg])
        else $error("running task in an empty slot");

endmodule
